[sv/cfdl_pkg.sv]
`timescale 1ns / 1ps

package cfdl_pkg;

    // Input request: one audio sample and the wanted delay (Q16.8 samples).
    typedef struct packed {
        logic signed [23:0] sample_in;
        logic        [23:0] target_delay;
    } t_in;

    // Result: mixed sample and crossfade status after this sample.
    typedef struct packed {
        logic signed [23:0] sample_out;
        logic               fade_active;
    } t_out;

    // Configuration register indexes.
    localparam logic CFG_FADE_LENGTH   = 1'b0;
    localparam logic CFG_INITIAL_DELAY = 1'b1;

    localparam logic [15:0] FADE_LEN_RST  = 16'd9600;
    localparam logic [23:0] INIT_DLY_RST  = 24'd0;
    localparam logic [16:0] GAIN_ONE      = 17'h10000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_MOD,
        S_POS,
        S_RD0,
        S_RD1,
        S_RD2,
        S_INT,
        S_SUM,
        S_MAC,
        S_ACC,
        S_FADE,
        S_DVCHK,
        S_DIV,
        S_GAIN,
        S_DONE
    } t_state;

endpackage

[sv/cfdl_ram.sv]
`timescale 1ns / 1ps

module cfdl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/crossfade_fractional_delay_line.sv]
`timescale 1ns / 1ps

// Crossfading fractional delay line. Each input request carries one signed
// Q1.23 sample and a wanted delay in samples (unsigned Q16.8). Two taps read
// the circular sample store with linear interpolation, are weighted by their
// Q1.16 gains and summed, rounded and saturated into sample_out; the new
// sample is then stored and the write head advances. A changed delay, when
// no fade runs, goes to the spare tap and a linear crossfade of fade_length
// samples starts; at its end the taps swap roles, and fade_active reports a
// running fade. One request is in work at a time, its steps serialised over
// the single read port of the sample store (two reads per tap), the one
// shared multiplier (interpolation and gain for each tap), and the one shared
// compare/subtract unit that reduces a delay modulo the depth and runs the
// gain division one quotient bit per cycle; the division is skipped for the
// last two samples of a fade, where the gain clamps to one. Unwritten store
// entries read as zero through a fill mark on the write head, so no clearing
// pass is needed after reset. A finished result waits in the output
// register while the next request is accepted. Configuration writes take
// effect at once and are always ready.

module crossfade_fractional_delay_line #(
    parameter int BUFFER_DEPTH = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input request channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  cfdl_pkg::t_in    i_in_data,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output cfdl_pkg::t_out   o_out_data,
    // configuration write channel
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [23:0]      i_cfg_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    // working width of a delay's whole part before and after reduction
    localparam int PW = (AW > 16) ? AW : 16;
    // width of the shared compare/subtract unit
    localparam int SW = 34;
    localparam int CW = 4;
    // binary reduction steps for the whole delay modulo the depth
    localparam int MOD_STEPS = (BUFFER_DEPTH > 65535) ? 0 : 17 - $clog2(BUFFER_DEPTH);
    localparam logic [AW:0]   DEPTH_W = (AW+1)'(BUFFER_DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(BUFFER_DEPTH - 1);

    // sequencer and datapath registers
    cfdl_pkg::t_state r_state, n_state;
    logic             r_tap, n_tap;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [PW-1:0]    r_whole, n_whole;
    logic [AW-1:0]    r_pos, n_pos;
    logic [AW-1:0]    r_next, n_next;
    logic [8:0]       r_t, n_t;
    logic             r_vld, n_vld;
    logic signed [23:0] r_a, n_a;
    logic signed [23:0] r_b, n_b;
    logic signed [51:0] r_prod, n_prod;
    logic signed [33:0] r_tapv, n_tapv;
    logic signed [51:0] r_acc, n_acc;
    logic signed [23:0] r_sample, n_sample;
    logic [23:0]      r_target, n_target;
    logic [16:0]      r_quot, n_quot;
    logic [16:0]      r_rem, n_rem;

    // delay line state
    logic [AW-1:0]    r_wp, n_wp;
    logic             r_wrapped, n_wrapped;
    logic [23:0]      r_dly [2];
    logic [23:0]      n_dly [2];
    logic [23:0]      r_cur, n_cur;
    logic [16:0]      r_gain [2];
    logic [16:0]      n_gain [2];
    logic [16:0]      r_fcount, n_fcount;
    logic             r_fading, n_fading;
    logic             r_main, n_main;
    logic [15:0]      r_fade_len, n_fade_len;

    // output register
    logic             r_out_valid, n_out_valid;
    cfdl_pkg::t_out   r_out, n_out;

    // shared units
    logic [SW-1:0]      sub_a, sub_b;
    logic [SW:0]        sub_d;
    logic               sub_ge;
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [51:0] mul_p;

    // sample store
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [23:0]        ram_rdata;

    // helpers
    logic [15:0]        len;
    logic [AW-1:0]      whole_a, pos0, pos1, nxt;
    logic [7:0]         frac;
    logic               cfg_we;
    logic               in_take;
    logic signed [51:0] rnd;
    logic signed [27:0] res;
    logic signed [23:0] sat;

    cfdl_ram #(
        .WIDTH (24),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (r_sample),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != cfdl_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_take = i_in_valid && !o_in_stall;
    assign cfg_we  = i_cfg_valid && o_cfg_ready;

    // zero fade length acts as one
    assign len = (r_fade_len == 16'd0) ? 16'd1 : r_fade_len;

    // second read of a tap fetches the following slot
    assign ram_raddr = (r_state == cfdl_pkg::S_RD1) ? r_next : r_pos;
    assign ram_we    = (r_state == cfdl_pkg::S_FADE);

    // shared compare/subtract unit
    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = ~sub_d[SW];

    // shared multiplier
    assign mul_p = mul_a * mul_b;

    always_comb begin
        sub_a = '0;
        sub_b = '0;
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            cfdl_pkg::S_MOD: begin
                sub_a = SW'(r_whole);
                sub_b = SW'(BUFFER_DEPTH) << r_cnt;
            end
            cfdl_pkg::S_DVCHK: begin
                sub_a = SW'(r_fcount);
                sub_b = SW'(len);
            end
            cfdl_pkg::S_DIV: begin
                sub_a = SW'({r_rem, 1'b0});
                sub_b = SW'(len);
            end
            cfdl_pkg::S_INT: begin
                mul_a = 34'(r_b) - 34'(r_a);
                mul_b = 18'(r_t);
            end
            cfdl_pkg::S_MAC: begin
                mul_a = r_tapv;
                mul_b = signed'({1'b0, r_gain[r_tap]});
            end
            default: begin
            end
        endcase
    end

    // read point of the current tap: write head minus whole part, one slot
    // further back when there is a fraction
    always_comb begin
        whole_a = r_whole[AW-1:0];
        frac    = r_dly[r_tap][7:0];
        if (r_wp >= whole_a) begin
            pos0 = r_wp - whole_a;
        end else begin
            pos0 = AW'({1'b0, r_wp} + DEPTH_W - {1'b0, whole_a});
        end
        if (frac != 8'd0) begin
            pos1 = (pos0 == '0) ? LAST : pos0 - AW'(1);
        end else begin
            pos1 = pos0;
        end
        nxt = (pos1 == LAST) ? '0 : pos1 + AW'(1);
    end

    // round half up, then saturate to 24 bits
    always_comb begin
        rnd = r_acc + 52'sd8388608;
        res = 28'(rnd >>> 24);
        if (res > 28'sd8388607) begin
            sat = 24'sd8388607;
        end else if (res < -28'sd8388608) begin
            sat = -24'sd8388608;
        end else begin
            sat = 24'(res);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_tap       = r_tap;
        n_cnt       = r_cnt;
        n_whole     = r_whole;
        n_pos       = r_pos;
        n_next      = r_next;
        n_t         = r_t;
        n_vld       = r_vld;
        n_a         = r_a;
        n_b         = r_b;
        n_prod      = r_prod;
        n_tapv      = r_tapv;
        n_acc       = r_acc;
        n_sample    = r_sample;
        n_target    = r_target;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_wp        = r_wp;
        n_wrapped   = r_wrapped;
        n_dly       = r_dly;
        n_cur       = r_cur;
        n_gain      = r_gain;
        n_fcount    = r_fcount;
        n_fading    = r_fading;
        n_main      = r_main;
        n_fade_len  = r_fade_len;
        n_out       = r_out;
        // drop the result once taken
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            cfdl_pkg::S_IDLE: begin
                if (in_take) begin
                    n_sample = i_in_data.sample_in;
                    n_target = i_in_data.target_delay;
                    n_acc    = '0;
                    n_tap    = 1'b0;
                    n_state  = cfdl_pkg::S_LOAD;
                end
            end
            cfdl_pkg::S_LOAD: begin
                n_whole = PW'(r_dly[r_tap][23:8]);
                n_cnt   = CW'(MOD_STEPS - 1);
                n_state = (MOD_STEPS == 0) ? cfdl_pkg::S_POS : cfdl_pkg::S_MOD;
            end
            cfdl_pkg::S_MOD: begin
                // subtract the depth shifted by the step when it fits
                if (sub_ge) begin
                    n_whole = PW'(sub_d);
                end
                if (r_cnt == '0) begin
                    n_state = cfdl_pkg::S_POS;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            cfdl_pkg::S_POS: begin
                n_pos   = pos1;
                n_next  = nxt;
                n_t     = (frac != 8'd0) ? 9'd256 - {1'b0, frac} : 9'd0;
                n_state = cfdl_pkg::S_RD0;
            end
            cfdl_pkg::S_RD0: begin
                n_vld   = r_wrapped || (r_pos < r_wp);
                n_state = cfdl_pkg::S_RD1;
            end
            cfdl_pkg::S_RD1: begin
                // never-written slots read as zero
                n_a     = r_vld ? signed'(ram_rdata) : 24'sd0;
                n_vld   = r_wrapped || (r_next < r_wp);
                n_state = cfdl_pkg::S_RD2;
            end
            cfdl_pkg::S_RD2: begin
                n_b     = r_vld ? signed'(ram_rdata) : 24'sd0;
                n_state = cfdl_pkg::S_INT;
            end
            cfdl_pkg::S_INT: begin
                n_prod  = mul_p;
                n_state = cfdl_pkg::S_SUM;
            end
            cfdl_pkg::S_SUM: begin
                n_tapv  = (34'(r_a) <<< 8) + 34'(r_prod);
                n_state = cfdl_pkg::S_MAC;
            end
            cfdl_pkg::S_MAC: begin
                n_prod  = mul_p;
                n_state = cfdl_pkg::S_ACC;
            end
            cfdl_pkg::S_ACC: begin
                n_acc = r_acc + r_prod;
                if (r_tap) begin
                    n_state = cfdl_pkg::S_FADE;
                end else begin
                    n_tap   = 1'b1;
                    n_state = cfdl_pkg::S_LOAD;
                end
            end
            cfdl_pkg::S_FADE: begin
                // store the sample and advance the write head
                if (r_wp == LAST) begin
                    n_wp      = '0;
                    n_wrapped = 1'b1;
                end else begin
                    n_wp = r_wp + AW'(1);
                end
                // load a changed delay into the spare tap and start a fade
                if ((r_target != r_cur) && !r_fading) begin
                    n_fading        = 1'b1;
                    n_cur           = r_target;
                    n_dly[~r_main]  = r_target;
                end
                if ((r_target != r_cur) || r_fading) begin
                    n_fcount = r_fcount + 17'd1;
                    n_state  = cfdl_pkg::S_DVCHK;
                end else begin
                    n_state = cfdl_pkg::S_DONE;
                end
            end
            cfdl_pkg::S_DVCHK: begin
                // gain clamps to one once the count reaches the length
                if (sub_ge) begin
                    n_quot  = cfdl_pkg::GAIN_ONE;
                    n_state = cfdl_pkg::S_GAIN;
                end else begin
                    n_quot  = '0;
                    n_rem   = r_fcount;
                    n_cnt   = CW'(15);
                    n_state = cfdl_pkg::S_DIV;
                end
            end
            cfdl_pkg::S_DIV: begin
                // restoring division, one quotient bit per cycle
                n_rem  = sub_ge ? 17'(sub_d) : 17'({r_rem, 1'b0});
                n_quot = {r_quot[15:0], sub_ge};
                if (r_cnt == '0) begin
                    n_state = cfdl_pkg::S_GAIN;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            cfdl_pkg::S_GAIN: begin
                n_gain[r_main]  = cfdl_pkg::GAIN_ONE - r_quot;
                n_gain[~r_main] = r_quot;
                // end of fade: swap tap roles
                if (r_fcount > 17'(len)) begin
                    n_fading = 1'b0;
                    n_fcount = '0;
                    n_main   = ~r_main;
                end
                n_state = cfdl_pkg::S_DONE;
            end
            cfdl_pkg::S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out.sample_out  = sat;
                    n_out.fade_active = r_fading;
                    n_out_valid       = 1'b1;
                    n_state           = cfdl_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cfdl_pkg::S_IDLE;
            end
        endcase

        if (cfg_we) begin
            unique case (i_cfg_index)
                cfdl_pkg::CFG_FADE_LENGTH: begin
                    n_fade_len = i_cfg_data[15:0];
                end
                cfdl_pkg::CFG_INITIAL_DELAY: begin
                    n_cur          = i_cfg_data;
                    n_dly[r_main]  = i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfdl_pkg::S_IDLE;
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_dly[0]    <= cfdl_pkg::INIT_DLY_RST;
            r_dly[1]    <= '0;
            r_cur       <= cfdl_pkg::INIT_DLY_RST;
            r_gain[0]   <= cfdl_pkg::GAIN_ONE;
            r_gain[1]   <= '0;
            r_fcount    <= '0;
            r_fading    <= 1'b0;
            r_main      <= 1'b0;
            r_fade_len  <= cfdl_pkg::FADE_LEN_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_wrapped   <= n_wrapped;
            r_dly       <= n_dly;
            r_cur       <= n_cur;
            r_gain      <= n_gain;
            r_fcount    <= n_fcount;
            r_fading    <= n_fading;
            r_main      <= n_main;
            r_fade_len  <= n_fade_len;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_tap    <= n_tap;
        r_cnt    <= n_cnt;
        r_whole  <= n_whole;
        r_pos    <= n_pos;
        r_next   <= n_next;
        r_t      <= n_t;
        r_vld    <= n_vld;
        r_a      <= n_a;
        r_b      <= n_b;
        r_prod   <= n_prod;
        r_tapv   <= n_tapv;
        r_acc    <= n_acc;
        r_sample <= n_sample;
        r_target <= n_target;
        r_quot   <= n_quot;
        r_rem    <= n_rem;
        r_out    <= n_out;
    end

endmodule

[sv/cfdl_chk.sv]
`timescale 1ns / 1ps

module cfdl_chk (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           o_in_stall,
    input  cfdl_pkg::t_in  i_in_data,
    input  logic           o_out_valid,
    input  logic           i_out_stall,
    input  cfdl_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    input  logic           o_cfg_ready,
    input  logic           i_cfg_index,
    input  logic [23:0]    i_cfg_data
);

    logic       in_take;
    logic       out_take;
    logic [1:0] r_pending;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_take = o_out_valid && !i_out_stall;

    // requests accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {1'b0, in_take} - {1'b0, out_take};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_in_stall)
        else $error("input not stalled while a request is in work");

    a_no_orphan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 2'd0)
        else $error("result shown without an accepted request");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3 && !(r_pending == 2'd2 && !o_in_stall))
        else $error("more requests outstanding than the block can hold");

    // configuration port is unused by the properties above but kept visible
    logic unused_cfg;
    assign unused_cfg = i_cfg_valid ^ o_cfg_ready ^ i_cfg_index ^ (^i_cfg_data)
                        ^ (^i_in_data);

endmodule

bind crossfade_fractional_delay_line cfdl_chk u_cfdl_chk (.*);

[tb/tb_crossfade_fractional_delay_line.sv]
`timescale 1ns / 1ps

// Self-checking bench for the crossfading fractional delay line. A
// queue-fed driver pushes requests in random bursts, a receiver stalls on a
// run-length pattern of its own, and a monitor checks every result against
// a bit-exact software copy of the delay line. The copy is advanced when a
// request is accepted.
module tb_crossfade_fractional_delay_line;
    import cfdl_pkg::*;

    localparam int DEPTH        = 65536;
    // Allow many times the slowest request's work, receiver stall and sender
    // gap together with no handshake at all.
    localparam int IDLE_LIMIT   = 5000;
    localparam int MAX_REPORTED = 10;
    localparam int DRAIN_CYCLES = 64;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in         in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out        out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_FADE_LENGTH;
    logic [23:0] cfg_data  = '0;

    // Throttle switches sender gaps and receiver stalls on or off per phase.
    logic        throttle  = 1'b1;

    t_in  pending_req[$];
    t_out expected_mix[$];

    int items_taken    = 0;
    int results_seen   = 0;
    int fades_seen     = 0;
    int reg_writes     = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;
    int gap_left       = 0;
    int burst_left     = 0;
    int stall_run      = 0;
    logic stall_phase  = 1'b0;
    logic last_fade    = 1'b0;
    t_out mon_want;

    // Shadow copy of the delay line state.
    logic signed [23:0] line_store [0:DEPTH-1];
    logic [15:0] line_wpos;
    logic [23:0] line_tap_delay [0:1];
    logic [23:0] line_cur_delay;
    logic [16:0] line_gain [0:1];
    logic [16:0] line_fade_count;
    logic        line_fading;
    logic        line_main;
    logic [15:0] line_fade_len;

    crossfade_fractional_delay_line uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic clear_line();
        for (int k = 0; k < DEPTH; k++) begin
            line_store[k] = '0;
        end
        line_fade_len     = FADE_LEN_RST;
        line_wpos         = '0;
        line_tap_delay[0] = INIT_DLY_RST;
        line_tap_delay[1] = '0;
        line_cur_delay    = INIT_DLY_RST;
        line_gain[0]      = GAIN_ONE;
        line_gain[1]      = '0;
        line_fade_count   = '0;
        line_fading       = 1'b0;
        line_main         = 1'b0;
    endtask

    // Linear interpolation between two neighbors, 8 extra fraction bits.
    // The read point sits delay samples behind the write head; a nonzero
    // fraction steps one slot further back and weights toward the newer one.
    function automatic longint interp_tap(logic [23:0] dly);
        logic [15:0] pos;
        logic [15:0] pos_next;
        logic [8:0]  weight;
        longint      older;
        longint      newer;
        pos    = line_wpos - dly[23:8];
        weight = '0;
        if (dly[7:0] != 8'd0) begin
            pos    = pos - 16'd1;
            weight = 9'd256 - dly[7:0];
        end
        pos_next = pos + 16'd1;
        older = line_store[pos];
        newer = line_store[pos_next];
        return older * 256 + (newer - older) * longint'(weight);
    endfunction

    // Advance the shadow line by one request and queue the result it owes.
    task automatic delay_line_step(input t_in req);
        logic [15:0] len;
        logic        spare;
        longint      acc;
        longint      mixed;
        longint      gain;
        t_out        res;
        len   = (line_fade_len == 16'd0) ? 16'd1 : line_fade_len;
        spare = ~line_main;

        // Read both taps before the write; round half up, then saturate.
        acc = interp_tap(line_tap_delay[0]) * longint'(line_gain[0])
            + interp_tap(line_tap_delay[1]) * longint'(line_gain[1]);
        mixed = (acc + (longint'(1) <<< 23)) >>> 24;
        if (mixed > 8388607) begin
            mixed = 8388607;
        end
        if (mixed < -8388608) begin
            mixed = -8388608;
        end

        line_store[line_wpos] = req.sample_in;

        // Start a fade on a new target; ignore target changes while fading.
        if (req.target_delay != line_cur_delay && !line_fading) begin
            line_fading = 1'b1;
            line_cur_delay = req.target_delay;
            line_tap_delay[spare] = req.target_delay;
        end
        if (line_fading) begin
            line_fade_count = line_fade_count + 17'd1;
            gain = (longint'(line_fade_count) <<< 16) / longint'(len);
            if (gain > GAIN_ONE) begin
                gain = GAIN_ONE;
            end
            line_gain[line_main] = GAIN_ONE - gain[16:0];
            line_gain[spare]     = gain[16:0];
        end
        // Swap roles once the count passes the (possibly shortened) length.
        if (line_fade_count > len) begin
            line_fading     = 1'b0;
            line_fade_count = '0;
            line_main       = spare;
        end
        line_wpos = line_wpos + 16'd1;

        res.sample_out  = mixed[23:0];
        res.fade_active = line_fading;
        expected_mix.push_back(res);
    endtask

    // Write one register and mirror it into the shadow line.
    task automatic write_reg(input logic idx, input logic [23:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_FADE_LENGTH) begin
            line_fade_len = value[15:0];
        end else begin
            // A new initial delay also retargets the main tap at once.
            line_cur_delay            = value;
            line_tap_delay[line_main] = value;
        end
        reg_writes++;
    endtask

    task automatic queue_req(input logic [23:0] smp, input logic [23:0] dly);
        t_in req;
        req.sample_in    = smp;
        req.target_delay = dly;
        pending_req.push_back(req);
    endtask

    // Mostly short delays so taps read recent samples; now and then anything.
    function automatic logic [23:0] pick_delay();
        logic [23:0] dly;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: dly = {8'd0, 8'($urandom_range(0, 48)), 8'($urandom)};
            5, 6:          dly = {8'd0, 8'($urandom_range(0, 48)), 8'd0};
            7:             dly = 24'($urandom);
            8:             dly = {16'($urandom), 8'd0};
            default:       dly = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'd0;
        endcase
        return dly;
    endfunction

    // Hold each target for a run so fades get to finish; a stray one-off
    // target now and then lands in the middle of a fade.
    task automatic queue_random(input int count);
        logic [23:0] dly;
        int          hold;
        dly  = pick_delay();
        hold = 0;
        for (int n = 0; n < count; n++) begin
            if (hold == 0) begin
                if ($urandom_range(0, 7) != 0) begin
                    dly = pick_delay();
                end
                hold = $urandom_range(1, 14);
            end
            hold--;
            if ($urandom_range(0, 15) == 0) begin
                queue_req(24'($urandom), pick_delay());
            end else begin
                queue_req(24'($urandom), dly);
            end
        end
    endtask

    // Block until every queued request has gone in and every result is back.
    task automatic wait_idle();
        while (pending_req.size() != 0 || in_valid || expected_mix.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic run_phase(input logic [15:0] fade, input logic [23:0] init_dly,
                             input logic thr, input int count);
        write_reg(CFG_FADE_LENGTH, {8'd0, fade});
        write_reg(CFG_INITIAL_DELAY, init_dly);
        throttle = thr;
        queue_random(count);
        wait_idle();
    endtask

    // Sender: feed requests from the queue in bursts with random gaps.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            gap_left   = 0;
            burst_left = 0;
        end else begin
            if (in_valid && !in_stall) begin
                delay_line_step(in_data);
                items_taken++;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_req.size() != 0) begin
                    in_data  <= pending_req.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        if (!throttle) begin
                            gap_left = 0;
                        end else if ($urandom_range(0, 3) == 0) begin
                            gap_left = $urandom_range(10, 60);
                        end else begin
                            gap_left = $urandom_range(0, 4);
                        end
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: alternate runs of stall and accept of random length.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall   <= 1'b0;
            stall_run   = 0;
            stall_phase = 1'b0;
        end else if (!throttle) begin
            out_stall <= 1'b0;
        end else begin
            if (stall_run == 0) begin
                stall_phase = ~stall_phase;
                stall_run   = stall_phase ? $urandom_range(1, 40) : $urandom_range(1, 30);
            end
            stall_run--;
            out_stall <= stall_phase;
        end
    end

    // Monitor: check each accepted result against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (out_data.fade_active && !last_fade) begin
                fades_seen++;
            end
            last_fade = out_data.fade_active;
            if (expected_mix.size() == 0) begin
                if (mismatches < MAX_REPORTED) begin
                    $display("result %0d arrived with nothing expected: sample_out %h",
                             results_seen, out_data.sample_out);
                end
                mismatches++;
            end else begin
                mon_want = expected_mix.pop_front();
                if (mon_want.sample_out !== out_data.sample_out
                        || mon_want.fade_active !== out_data.fade_active) begin
                    if (mismatches < MAX_REPORTED) begin
                        $display("result %0d: expected sample_out %h fade_active %b,",
                                 results_seen, mon_want.sample_out, mon_want.fade_active);
                        $display("    got sample_out %h fade_active %b",
                                 out_data.sample_out, out_data.fade_active);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if no handshake of any kind happens for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, expected_mix.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clear_line();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Sample extremes on a steady fractional delay of 2.5 samples.
        write_reg(CFG_FADE_LENGTH, 24'd3);
        write_reg(CFG_INITIAL_DELAY, 24'h000280);
        queue_req(24'h7FFFFF, 24'h000280);
        queue_req(24'h800000, 24'h000280);
        queue_req(24'h000000, 24'h000280);
        queue_req(24'hFFFFFF, 24'h000280);
        queue_req(24'h000001, 24'h000280);
        queue_req(24'h555555, 24'h000280);
        queue_req(24'hAAAAAA, 24'h000280);
        // New target starts a fade; the next change waits for it to end,
        // then a still-differing target starts a second fade.
        queue_req(24'h7FFFFF, 24'h000400);
        queue_req(24'h800000, 24'h000180);
        queue_req(24'h123456, 24'h000180);
        queue_req(24'h654321, 24'h000180);
        queue_req(24'h7FFFFF, 24'h000180);
        queue_req(24'h7FFFFF, 24'h000180);
        queue_req(24'h7FFFFF, 24'h000180);
        // Largest delay wraps the read point; zero delay reads the slot
        // about to be overwritten.
        queue_req(24'h000000, 24'hFFFFFF);
        queue_req(24'h800000, 24'hFFFFFF);
        queue_req(24'h000000, 24'h000000);
        wait_idle();

        // Zero fade length acts as one sample.
        write_reg(CFG_FADE_LENGTH, 24'd0);
        queue_req(24'h7FFFFF, 24'h000000);
        queue_req(24'h800000, 24'h000100);
        queue_req(24'h000001, 24'h000101);
        queue_req(24'h3FFFFF, 24'h000101);
        wait_idle();

        // Start a long fade from the largest initial delay, then shorten the
        // fade length while it runs so it ends on the next request.
        write_reg(CFG_FADE_LENGTH, 24'h00FFFF);
        write_reg(CFG_INITIAL_DELAY, 24'hFFFFFF);
        queue_req(24'h400000, 24'h000300);
        queue_req(24'hC00000, 24'h000300);
        queue_req(24'h0F0F0F, 24'h000300);
        wait_idle();
        write_reg(CFG_FADE_LENGTH, 24'd2);
        queue_req(24'hF0F0F0, 24'h000300);
        queue_req(24'h111111, 24'h000500);
        wait_idle();

        // Random phases across fade lengths and initial delays.
        run_phase(16'd1, 24'h000000, 1'b1, 80);
        run_phase(16'd7, {8'd0, 8'($urandom_range(0, 48)), 8'($urandom)}, 1'b1, 80);
        run_phase(16'd0, 24'hFFFFFF, 1'b0, 60);
        run_phase(16'd16, {8'd0, 8'($urandom_range(0, 48)), 8'd0}, 1'b1, 80);
        run_phase(16'hFFFF, {8'd0, 8'($urandom_range(0, 48)), 8'($urandom)}, 1'b1, 50);
        // Cut the long fade short and keep going.
        write_reg(CFG_FADE_LENGTH, 24'd4);
        throttle = 1'b1;
        queue_random(50);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_mix.size() != 0) begin
            $display("%0d results never arrived", expected_mix.size());
            mismatches++;
        end

        $display("Covered %0d requests and %0d checked results over %0d register writes,",
                 items_taken, results_seen, reg_writes);
        $display("with %0d crossfades across fade lengths from zero to the maximum.",
                 fades_seen);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[crossfade_fractional_delay_line.f]
sv/cfdl_pkg.sv
sv/cfdl_ram.sv
sv/crossfade_fractional_delay_line.sv
sv/cfdl_chk.sv
tb/tb_crossfade_fractional_delay_line.sv
